// ----- hdl/wgtp_pkg.sv -----
// Shared types and constants for the go-to-point controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package wgtp_pkg;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_OUT
    } state_t;

    // Configuration register indexes
    localparam logic [2:0] REG_GOAL_X         = 3'd0;
    localparam logic [2:0] REG_GOAL_Y         = 3'd1;
    localparam logic [2:0] REG_GOAL_HEADING   = 3'd2;
    localparam logic [2:0] REG_YAW_TOLERANCE  = 3'd3;
    localparam logic [2:0] REG_DIST_TOLERANCE = 3'd4;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int GOAL_W    = 16;
    localparam int GHEAD_W   = 15;
    localparam int YTOL_W    = 14;
    localparam int DTOL_W    = 16;

    localparam logic [YTOL_W-1:0] YTOL_RESET = 14'd143;
    localparam logic [DTOL_W-1:0] DTOL_RESET = 16'd50;

    // CORDIC: angle accumulator in 2^-16 rad, bearing out in Q3.12
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = 4;
    localparam int ZW           = 20;
    localparam int BEARING_W    = ZW - 4;
    localparam int POS_FRAC     = 16;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;

    localparam logic [7:0] FINAL_TOL = 8'd205;

    // Command values, units of 0.01
    localparam logic [4:0]        DRIVE_SPEED = 5'd20;
    localparam logic signed [7:0] TURN_RATE   = 8'sd65;
    localparam logic signed [7:0] STEER_RATE  = 8'sd10;
    localparam logic signed [7:0] ROTATE_RATE = 8'sd50;

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_TURN   = 2'd1;
    localparam logic [1:0] PHASE_DRIVE  = 2'd2;
    localparam logic [1:0] PHASE_ROTATE = 2'd3;

    // atan(2^-i) in units of 2^-16 rad, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30386;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            4'd15:   r = 20'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/waypoint_go_to_point_controller_core.sv -----
// out_valid rises after the input beat of an active tick once launch, the 16 CORDIC
// steps and decide are through, and in the cycle after the input beat of an idle tick;
// the CORDIC, not the distance unit, sets how long an active tick waits. out_stall holds
// the result beat; no new input beat is taken until the result beat leaves.
// Reset clears the phase flags (idle) and loads the register defaults.
// Top level: config registers, phase sequencer, CORDIC and distance units.
`default_nettype none

module waypoint_go_to_point_controller_core
    import wgtp_pkg::*;
#(
    parameter int POS_WIDTH   = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          start_req,
    input  wire logic signed [POS_WIDTH-1:0]   pos_x,
    input  wire logic signed [POS_WIDTH-1:0]   pos_y,
    input  wire logic signed [ANGLE_WIDTH-2:0] heading,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [4:0]                         linear_cmd,
    output logic signed [7:0]                  angular_cmd,
    output logic                               cmd_valid,
    output logic [1:0]                         phase,
    output logic                               done_res,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_data
);

    localparam int PW = POS_WIDTH;
    localparam int HW = ANGLE_WIDTH - 1;
    localparam int EW = ((ANGLE_WIDTH > BEARING_W) ? ANGLE_WIDTH : BEARING_W) + 2;

    state_t state_reg, state_next;

    logic [GOAL_W-1:0]  goal_x_reg, goal_y_reg;
    logic [GHEAD_W-1:0] goal_heading_reg;
    logic [YTOL_W-1:0]  yaw_tol_reg;
    logic [DTOL_W-1:0]  dist_tol_reg;

    logic active_reg, active_next;
    logic aligned_reg, aligned_next;
    logic arrived_reg, arrived_next;

    logic signed [PW:0]   dx_reg, dy_reg, dx_next, dy_next;
    logic signed [HW-1:0] hd_reg;

    logic [4:0]        lin_reg, lin_next;
    logic signed [7:0] ang_reg, ang_next;
    logic              valid_reg, valid_next;
    logic [1:0]        phase_reg, phase_next;
    logic              done_reg, done_next;

    logic in_beat, out_beat, go;
    logic cordic_busy, dist_busy, far;
    logic signed [BEARING_W-1:0] bearing;

    logic signed [PW-1:0] gx, gy;
    logic signed [HW-1:0] gh;
    logic signed [EW-1:0] err, ferr, aerr, aferr;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    assign gx = $signed(PW'(goal_x_reg));
    assign gy = $signed(PW'(goal_y_reg));
    assign gh = $signed(HW'(goal_heading_reg));
    assign dx_next = $signed({gx[PW-1], gx}) - $signed({pos_x[PW-1], pos_x});
    assign dy_next = $signed({gy[PW-1], gy}) - $signed({pos_y[PW-1], pos_y});

    assign err   = EW'(bearing) - EW'(hd_reg);
    assign ferr  = EW'(gh) - EW'(hd_reg);
    assign aerr  = err[EW-1] ? -err : err;
    assign aferr = ferr[EW-1] ? -ferr : ferr;

    wgtp_cordic #(
        .POS_WIDTH (POS_WIDTH)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .busy    (cordic_busy),
        .bearing (bearing)
    );

    wgtp_dist #(
        .POS_WIDTH (POS_WIDTH)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .tol   (dist_tol_reg),
        .busy  (dist_busy),
        .far   (far)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg       <= '0;
            goal_y_reg       <= '0;
            goal_heading_reg <= '0;
            yaw_tol_reg      <= YTOL_RESET;
            dist_tol_reg     <= DTOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GOAL_X:         goal_x_reg       <= cfg_data[GOAL_W-1:0];
                REG_GOAL_Y:         goal_y_reg       <= cfg_data[GOAL_W-1:0];
                REG_GOAL_HEADING:   goal_heading_reg <= cfg_data[GHEAD_W-1:0];
                REG_YAW_TOLERANCE:  yaw_tol_reg      <= cfg_data[YTOL_W-1:0];
                REG_DIST_TOLERANCE: dist_tol_reg     <= cfg_data[DTOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        active_next  = active_reg;
        aligned_next = aligned_reg;
        arrived_next = arrived_reg;
        lin_next     = lin_reg;
        ang_next     = ang_reg;
        valid_next   = valid_reg;
        phase_next   = phase_reg;
        done_next    = done_reg;
        go           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (start_req)
                    begin
                        active_next  = 1'b1;
                        aligned_next = 1'b0;
                        arrived_next = 1'b0;
                    end
                    if (start_req || active_reg)
                    begin
                        state_next = ST_LAUNCH;
                    end
                    else
                    begin
                        // idle tick: all-zero result
                        lin_next   = '0;
                        ang_next   = '0;
                        valid_next = 1'b0;
                        phase_next = PHASE_IDLE;
                        done_next  = 1'b0;
                        state_next = ST_OUT;
                    end
                end
            end

            ST_LAUNCH:
            begin
                go         = 1'b1;
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (!cordic_busy && !dist_busy)
                begin
                    lin_next   = '0;
                    ang_next   = '0;
                    valid_next = 1'b0;
                    phase_next = PHASE_IDLE;
                    done_next  = 1'b0;
                    // phases fall through within one tick once met
                    if (!aligned_next)
                    begin
                        if (aerr > EW'(yaw_tol_reg))
                        begin
                            valid_next = 1'b1;
                            phase_next = PHASE_TURN;
                            ang_next   = (err > 0) ? TURN_RATE : -TURN_RATE;
                        end
                        else
                        begin
                            aligned_next = 1'b1;
                        end
                    end
                    if (aligned_next && !arrived_next)
                    begin
                        if (far)
                        begin
                            valid_next = 1'b1;
                            phase_next = PHASE_DRIVE;
                            lin_next   = DRIVE_SPEED;
                            ang_next   = (err > 0) ? STEER_RATE : -STEER_RATE;
                        end
                        else
                        begin
                            arrived_next = 1'b1;
                        end
                    end
                    if (aligned_next && arrived_next)
                    begin
                        valid_next = 1'b1;
                        phase_next = PHASE_ROTATE;
                        lin_next   = '0;
                        if (aferr > EW'(FINAL_TOL))
                        begin
                            ang_next = (ferr > 0) ? ROTATE_RATE : -ROTATE_RATE;
                        end
                        else
                        begin
                            ang_next    = '0;
                            done_next   = 1'b1;
                            active_next = 1'b0;
                        end
                    end
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (out_beat)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            aligned_reg <= 1'b0;
            arrived_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            aligned_reg <= aligned_next;
            arrived_reg <= arrived_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            hd_reg <= heading;
        end
        lin_reg   <= lin_next;
        ang_reg   <= ang_next;
        valid_reg <= valid_next;
        phase_reg <= phase_next;
        done_reg  <= done_next;
    end

    assign linear_cmd  = lin_reg;
    assign angular_cmd = ang_reg;
    assign cmd_valid   = valid_reg;
    assign phase       = phase_reg;
    assign done_res    = done_reg;

    // a completed goal always leaves the block idle with a stop command
    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (cmd_valid && !active_reg && phase == PHASE_ROTATE
            && angular_cmd == 8'sd0 && linear_cmd == 5'd0))
        else $error("done result without stop command or with goal still active");

    // no command published means an all-zero result
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cmd_valid) |-> (linear_cmd == 5'd0 && angular_cmd == 8'sd0
            && phase == PHASE_IDLE && !done_res))
        else $error("unpublished result carries a command");

    // forward speed only in the drive phase
    a_drive_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((phase == PHASE_DRIVE) == (linear_cmd == DRIVE_SPEED)))
        else $error("linear command does not match phase");

    // units never busy while the sequencer waits for input or holds a result
    a_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_OUT) |-> (!cordic_busy && !dist_busy))
        else $error("arithmetic unit busy outside a tick");

    // every accepted beat is answered before the next one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("input taken while a tick is in flight");

endmodule

`default_nettype wire

// ----- hdl/wgtp_cordic.sv -----
// Iterative vectoring CORDIC: bearing of (dx, dy) in Q3.12 radians.
// One shared add/shift step per cycle; uses wgtp_pkg.
`default_nettype none

module wgtp_cordic
    import wgtp_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic signed [POS_WIDTH:0]   dx,
    input  wire logic signed [POS_WIDTH:0]   dy,
    output logic                             busy,
    output logic signed [BEARING_W-1:0]      bearing
);

    // room for the 2^16 scale, the sqrt(2) length and the CORDIC gain
    localparam int CW  = POS_WIDTH + 20;
    localparam int EXT = CW - POS_WIDTH - 1 - POS_FRAC;

    logic                    busy_reg;
    logic                    zero_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [CW-1:0]    x_reg, y_reg;
    logic signed [ZW-1:0]    z_reg;

    logic signed [CW-1:0]    x0, y0, xs, ys;
    logic signed [ZW-1:0]    zr;

    assign x0 = $signed({{EXT{dx[POS_WIDTH]}}, dx, {POS_FRAC{1'b0}}});
    assign y0 = $signed({{EXT{dy[POS_WIDTH]}}, dy, {POS_FRAC{1'b0}}});
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            zero_reg <= (dx == '0) && (dy == '0);
            // pre-rotate the left half plane by a quarter turn
            if (dx[POS_WIDTH])
            begin
                if (!dy[POS_WIDTH])
                begin
                    x_reg <= y0;
                    y_reg <= -x0;
                    z_reg <= HALF_PI_Q16;
                end
                else
                begin
                    x_reg <= -y0;
                    y_reg <= x0;
                    z_reg <= -HALF_PI_Q16;
                end
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_q16(step_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_q16(step_reg);
            end
        end
    end

    assign zr      = z_reg + ZW'(8);
    assign busy    = busy_reg;
    assign bearing = zero_reg ? '0 : $signed(zr[ZW-1:4]);

endmodule

`default_nettype wire

// ----- hdl/wgtp_dist.sv -----
// Distance test: far when dx^2 + dy^2 > tol^2, exact.
// One shared 16x16 multiplier squares dx, dy and then tol in turn; uses wgtp_pkg.
`default_nettype none

module wgtp_dist
    import wgtp_pkg::*;
#(
    parameter int POS_WIDTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire logic signed [POS_WIDTH:0]   dx,
    input  wire logic signed [POS_WIDTH:0]   dy,
    input  wire logic [DTOL_W-1:0]           tol,
    output logic                             busy,
    output logic                             far
);

    localparam int AW = POS_WIDTH + 1;
    localparam int MW = (AW > DTOL_W) ? AW : DTOL_W;

    logic               busy_reg;
    logic [1:0]         cnt_reg;
    logic [2*DTOL_W-1:0] prod_reg;
    logic [2*DTOL_W:0]   acc_reg;
    logic               far_reg;

    logic [AW-1:0]      ax, ay;
    logic               quick_far;
    logic [DTOL_W-1:0]  op;

    assign ax = dx[POS_WIDTH] ? AW'(-dx) : AW'(dx);
    assign ay = dy[POS_WIDTH] ? AW'(-dy) : AW'(dy);
    // past this check both magnitudes fit the multiplier
    assign quick_far = (MW'(ax) > MW'(tol)) || (MW'(ay) > MW'(tol));

    always_comb
    begin
        case (cnt_reg)
            2'd0:    op = DTOL_W'(ax);
            2'd1:    op = DTOL_W'(ay);
            default: op = tol;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            prod_reg <= op * op;
            case (cnt_reg)
                2'd1:    acc_reg <= {1'b0, prod_reg};
                2'd2:    acc_reg <= acc_reg + {1'b0, prod_reg};
                2'd3:    far_reg <= quick_far || (acc_reg > {1'b0, prod_reg});
                default: ;
            endcase
        end
    end

    assign busy = busy_reg;
    assign far  = far_reg;

endmodule

`default_nettype wire
